// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL. Empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/core/dlcr_pkg.sv -----
`default_nettype none

package dlcr_pkg;

  localparam int LED_COUNT       = 2;
  localparam int MODE_COUNT      = 10;
  localparam int WINDOW_SAMPLES  = 150;
  localparam int FLASH_ON_SAMPLE = 135;
  localparam int SUM_W           = 20;

  typedef logic [7:0]       duty_t;
  typedef logic [11:0]      amp_t;
  typedef logic [3:0]       mode_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [1:0]       rs_t;
  typedef logic [2:0]       cmd_t;

  localparam amp_t  TEMP_KNEE   = 12'd3200;
  localparam amp_t  TEMP_LIMIT  = 12'd3350;
  localparam duty_t DERATE_SPAN = 8'(TEMP_LIMIT - TEMP_KNEE);
  localparam logic [3:0] UP_SETTLE   = 4'd10;
  localparam logic [3:0] DOWN_SETTLE = 4'd2;
  localparam logic [3:0] SETTLE_MAX  = 4'd15;

  // ramp states
  localparam rs_t RS_STABLE = 2'd0;
  localparam rs_t RS_OFF    = 2'd1;
  localparam rs_t RS_UP     = 2'd2;
  localparam rs_t RS_DOWN   = 2'd3;

  // lane commands
  localparam cmd_t CMD_NOP   = 3'd0;
  localparam cmd_t CMD_EVAL  = 3'd1;
  localparam cmd_t CMD_APPLY = 3'd2;
  localparam cmd_t CMD_TICK  = 3'd3;
  localparam cmd_t CMD_ACCUM = 3'd4;
  localparam cmd_t CMD_REGUL = 3'd5;
  localparam cmd_t CMD_CLEAR = 3'd6;

  // config register indexes
  localparam logic [1:0] CFG_MARGIN  = 2'd0;
  localparam logic [1:0] CFG_TURN_ON = 2'd1;
  localparam logic [1:0] CFG_CEILING = 2'd2;

  typedef struct packed {
    cmd_t        cmd;
    mode_t       mode;
    mode_t       old_mode;
    amp_t        sample;
    logic [7:0]  samples;
    amp_t        avg_temp;
    duty_t       turn_on;
    duty_t       ceiling;
    logic [3:0]  margin;
  } lane_ctl_t;

  typedef struct packed {
    logic  busy;
    logic  stable;
    logic  moved;
    duty_t target;
  } lane_sts_t;

  function automatic duty_t peak_current(mode_t m, logic led);
    duty_t v;
    case (m)
      4'd1:    v = led ? 8'd135 : 8'd0;
      4'd2:    v = led ? 8'd90  : 8'd54;
      4'd3:    v = led ? 8'd0   : 8'd90;
      4'd4:    v = led ? 8'd0   : 8'd54;
      4'd6:    v = led ? 8'd45  : 8'd0;
      4'd7:    v = led ? 8'd135 : 8'd0;
      4'd8:    v = led ? 8'd45  : 8'd0;
      4'd9:    v = led ? 8'd0   : 8'd45;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic flash_mode(mode_t m);
    logic f;
    case (m)
      4'd3, 4'd4, 4'd6: f = 1'b1;
      default:          f = 1'b0;
    endcase
    return f;
  endfunction

  function automatic logic derate_mode(mode_t m);
    logic f;
    case (m)
      4'd1, 4'd2, 4'd7, 4'd9: f = 1'b1;
      default:                f = 1'b0;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] permit_code(mode_t m);
    logic [3:0] p;
    case (m)
      4'd1:    p = 4'd8;
      4'd5:    p = 4'd0;
      4'd6:    p = 4'd9;
      4'd8:    p = 4'd6;
      4'd9:    p = 4'd2;
      4'd0, 4'd2, 4'd3, 4'd4, 4'd7: p = 4'd1;
      default: p = 4'd0;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dlcr_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module dlcr_div #(
  parameter int NW = 20,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);
  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic [DW-1:0] rem_r, rem_nxt, den_r, den_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   shifted, diff;

  always_comb begin
    shifted  = {rem_r, q_r[NW-1]};
    diff     = shifted - {1'b0, den_r};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      rem_nxt  = '0;
      q_nxt    = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        q_nxt   = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign busy = busy_r;
  assign quo  = q_r;

endmodule

`default_nettype wire

// ----- rtl/core/dlcr_lane.sv -----
`default_nettype none

// One LED: duty target, ramp, settle, window sum, goal and mean evaluation.
module dlcr_lane (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                led_sel,
  input  wire dlcr_pkg::lane_ctl_t ctl,
  output dlcr_pkg::lane_sts_t      sts
);
  localparam logic [1:0] LS_IDLE = 2'd0;
  localparam logic [1:0] LS_MUL  = 2'd1;
  localparam logic [1:0] LS_DIV  = 2'd2;

  localparam logic [1:0] GS_PLAIN  = 2'd0;
  localparam logic [1:0] GS_HALF   = 2'd1;
  localparam logic [1:0] GS_DERATE = 2'd2;

  // derating quotient by reciprocal multiply, exact for any 16-bit product
  localparam int          GDIV_SH    = 16 + $clog2(dlcr_pkg::DERATE_SPAN);
  localparam logic [63:0] GDIV_RECIP =
    ((64'd1 << GDIV_SH) + 64'(dlcr_pkg::DERATE_SPAN) - 64'd1) / 64'(dlcr_pkg::DERATE_SPAN);

  logic [1:0]           lst_r, lst_nxt;
  dlcr_pkg::duty_t      target_r, target_nxt;
  dlcr_pkg::rs_t        ramp_r, ramp_nxt;
  logic [3:0]           settle_r, settle_nxt;
  dlcr_pkg::sum_t       sum_r, sum_nxt;
  dlcr_pkg::amp_t       last_r, last_nxt;
  logic                 moved_r, moved_nxt;
  dlcr_pkg::duty_t      goal_r, goal_nxt, m_r, m_nxt;
  dlcr_pkg::amp_t       mean_r, mean_nxt;
  logic [15:0]          prod_r, prod_nxt;
  logic [32:0]          gprod_r, gprod_nxt;
  logic [1:0]           gsel_r, gsel_nxt;
  logic                 use_mdiv_r, use_mdiv_nxt;

  logic                 mdiv_start, mbusy;
  dlcr_pkg::sum_t       mq;
  logic [7:0]           gq;
  dlcr_pkg::amp_t       tdiff;
  dlcr_pkg::duty_t      peak_new, peak_old, lim;
  logic [3:0]           settle_inc;
  logic [12:0]          mean_lo, goal_hi;

  dlcr_div #(.NW(dlcr_pkg::SUM_W), .DW(8)) u_mdiv (
    .clk(clk), .rst_n(rst_n), .start(mdiv_start), .num(sum_r), .den(ctl.samples),
    .busy(mbusy), .quo(mq)
  );

  always_comb begin
    peak_new   = dlcr_pkg::peak_current(ctl.mode, led_sel);
    peak_old   = dlcr_pkg::peak_current(ctl.old_mode, led_sel);
    lim        = peak_new;
    tdiff      = dlcr_pkg::TEMP_LIMIT - ctl.avg_temp;
    settle_inc = (settle_r == dlcr_pkg::SETTLE_MAX) ? settle_r : settle_r + 1'b1;
    mean_lo    = {1'b0, mean_r} + {9'b0, ctl.margin};
    goal_hi    = {5'b0, goal_r} + {9'b0, ctl.margin};
    gq         = gprod_r[GDIV_SH +: 8];

    lst_nxt      = lst_r;
    target_nxt   = target_r;
    ramp_nxt     = ramp_r;
    settle_nxt   = settle_r;
    sum_nxt      = sum_r;
    last_nxt     = last_r;
    moved_nxt    = moved_r;
    goal_nxt     = goal_r;
    mean_nxt     = mean_r;
    m_nxt        = m_r;
    prod_nxt     = prod_r;
    gprod_nxt    = gprod_r;
    gsel_nxt     = gsel_r;
    use_mdiv_nxt = use_mdiv_r;
    mdiv_start   = 1'b0;

    case (lst_r)
      LS_MUL: begin
        gprod_nxt = prod_r * GDIV_RECIP[16:0];
        lst_nxt   = LS_DIV;
      end
      LS_DIV: begin
        if (!mbusy) begin
          case (gsel_r)
            GS_HALF:   goal_nxt = {1'b0, m_r[7:1]};
            GS_DERATE: goal_nxt = {1'b0, m_r[7:1]} + {2'b0, gq[7:2]} + {4'b0, gq[7:4]};
            default:   goal_nxt = m_r;
          endcase
          mean_nxt = use_mdiv_r ? mq[11:0] : last_r;
          lst_nxt  = LS_IDLE;
        end
      end
      default: begin
      end
    endcase

    case (ctl.cmd)
      dlcr_pkg::CMD_EVAL: begin
        m_nxt    = peak_new;
        prod_nxt = peak_new * tdiff[7:0];
        if (dlcr_pkg::derate_mode(ctl.mode) && ctl.avg_temp > dlcr_pkg::TEMP_KNEE) begin
          gsel_nxt = (ctl.avg_temp > dlcr_pkg::TEMP_LIMIT) ? GS_HALF : GS_DERATE;
        end else begin
          gsel_nxt = GS_PLAIN;
        end
        use_mdiv_nxt = (ctl.samples != 8'd0);
        mdiv_start   = (ctl.samples != 8'd0);
        lst_nxt      = LS_MUL;
      end
      dlcr_pkg::CMD_APPLY: begin
        if (goal_r == 8'd0 && target_r != 8'd0) begin
          ramp_nxt = dlcr_pkg::RS_OFF;
        end else if ({4'b0, goal_r} > mean_r) begin
          ramp_nxt = dlcr_pkg::RS_UP;
        end else if ({4'b0, goal_r} < mean_r) begin
          ramp_nxt = dlcr_pkg::RS_DOWN;
        end
        settle_nxt = '0;
        sum_nxt    = '0;
        // LED switched on between two lit modes starts from the turn-on duty
        if (ctl.old_mode != 4'd0 && ctl.mode != 4'd0 && peak_old == 8'd0 &&
            peak_new != 8'd0) begin
          target_nxt = ctl.turn_on;
        end
      end
      dlcr_pkg::CMD_TICK: begin
        last_nxt  = ctl.sample;
        moved_nxt = 1'b0;
        case (ramp_r)
          dlcr_pkg::RS_OFF: begin
            if (target_r != 8'd0) begin
              target_nxt = target_r - 1'b1;
              moved_nxt  = 1'b1;
            end else begin
              ramp_nxt = dlcr_pkg::RS_STABLE;
            end
          end
          dlcr_pkg::RS_UP: begin
            if (ctl.sample < {4'b0, lim}) begin
              settle_nxt = '0;
              moved_nxt  = 1'b1;
              target_nxt = (target_r < ctl.ceiling) ? target_r + 1'b1 : ctl.ceiling;
            end else begin
              settle_nxt = settle_inc;
              if (settle_inc > dlcr_pkg::UP_SETTLE) ramp_nxt = dlcr_pkg::RS_STABLE;
            end
          end
          dlcr_pkg::RS_DOWN: begin
            if (ctl.sample > {4'b0, lim}) begin
              settle_nxt = '0;
              moved_nxt  = 1'b1;
              if (target_r == 8'd0) begin
                target_nxt = 8'd0;
              end else if (target_r > ctl.ceiling) begin
                target_nxt = ctl.ceiling;
              end else begin
                target_nxt = target_r - 1'b1;
              end
            end else begin
              settle_nxt = settle_inc;
              if (settle_inc > dlcr_pkg::DOWN_SETTLE) ramp_nxt = dlcr_pkg::RS_STABLE;
            end
          end
          default: begin
          end
        endcase
      end
      dlcr_pkg::CMD_ACCUM: begin
        sum_nxt = sum_r + {8'b0, last_r};
      end
      dlcr_pkg::CMD_REGUL: begin
        if (goal_r != 8'd0) begin
          if (mean_lo < {5'b0, goal_r}) begin
            if (target_r != 8'hFF) target_nxt = target_r + 1'b1;
            moved_nxt = 1'b1;
          end else if ({1'b0, mean_r} > goal_hi) begin
            if (target_r != 8'd0) target_nxt = target_r - 1'b1;
            moved_nxt = 1'b1;
          end
        end
      end
      dlcr_pkg::CMD_CLEAR: begin
        sum_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lst_r    <= LS_IDLE;
      target_r <= '0;
      ramp_r   <= dlcr_pkg::RS_STABLE;
      settle_r <= '0;
      sum_r    <= '0;
      last_r   <= '0;
      moved_r  <= 1'b0;
    end else begin
      lst_r    <= lst_nxt;
      target_r <= target_nxt;
      ramp_r   <= ramp_nxt;
      settle_r <= settle_nxt;
      sum_r    <= sum_nxt;
      last_r   <= last_nxt;
      moved_r  <= moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    goal_r     <= goal_nxt;
    mean_r     <= mean_nxt;
    m_r        <= m_nxt;
    prod_r     <= prod_nxt;
    gprod_r    <= gprod_nxt;
    gsel_r     <= gsel_nxt;
    use_mdiv_r <= use_mdiv_nxt;
  end

  assign sts.busy   = (lst_r != LS_IDLE);
  assign sts.stable = (ramp_r == dlcr_pkg::RS_STABLE);
  assign sts.moved  = moved_r;
  assign sts.target = target_r;

endmodule

`default_nettype wire

// ----- rtl/core/dual_led_current_regulator.sv -----
`default_nettype none

// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: action; tdata: mode, amp1, amp2, temp
// out_     out  out_tvalid/out_tready tdata: duty1, duty2, mode, stable, written
// cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data (always ready)
//
// One transaction at a time. A mode request adds a lane evaluation (with a lane mean
// division if the window holds samples); a window end in a non-flashing mode adds the
// temperature average by reciprocal multiply, then the lane divisions.
// Lane mean dividers produce one quotient bit per cycle.
// rst_n is synchronous, active low. A finished result sits in the output
// register; the next input is taken meanwhile, and the sequencer holds at the
// end of that item until the output register is free.
module dual_led_current_regulator #(
  parameter int WINDOW_SAMPLES  = dlcr_pkg::WINDOW_SAMPLES,
  parameter int FLASH_ON_SAMPLE = dlcr_pkg::FLASH_ON_SAMPLE
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,  // requested_mode, amp_first, amp_second, temp_sample
  input  wire logic [0:0]  in_tuser,  // action
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata, // duty_first, duty_second, lamp_mode, all_stable,
                                      // duty_written, zero pad
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  localparam int NL = dlcr_pkg::LED_COUNT;

  // window temperature sum stays below 2^SUM_W, so the reciprocal is exact
  localparam int          TDIV_SH    = dlcr_pkg::SUM_W + $clog2(WINDOW_SAMPLES);
  localparam logic [63:0] TDIV_RECIP =
    ((64'd1 << TDIV_SH) + 64'(WINDOW_SAMPLES) - 64'd1) / 64'(WINDOW_SAMPLES);

  localparam logic [3:0] ST_IDLE      = 4'd0;
  localparam logic [3:0] ST_REQ_EVAL  = 4'd1;
  localparam logic [3:0] ST_REQ_WAIT  = 4'd2;
  localparam logic [3:0] ST_APPLY     = 4'd3;
  localparam logic [3:0] ST_TICK      = 4'd4;
  localparam logic [3:0] ST_ACC       = 4'd5;
  localparam logic [3:0] ST_TEMP      = 4'd6;
  localparam logic [3:0] ST_REG_EVAL  = 4'd8;
  localparam logic [3:0] ST_REG_WAIT  = 4'd9;
  localparam logic [3:0] ST_REGUL     = 4'd10;
  localparam logic [3:0] ST_CLEAR     = 4'd11;
  localparam logic [3:0] ST_FIN       = 4'd12;

  logic [3:0]          st_r, st_nxt;
  dlcr_pkg::mode_t     mode_r, mode_nxt, want_r;
  logic [7:0]          samples_r, samples_nxt, cnt1;
  dlcr_pkg::sum_t      tsum_r, tsum_nxt;
  dlcr_pkg::amp_t      avg_r, avg_nxt;
  dlcr_pkg::duty_t     driven_r [NL], driven_nxt [NL];
  logic                wr_r, wr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [23:0]         out_data_r, out_data_nxt;
  logic [3:0]          margin_r;
  dlcr_pkg::duty_t     turnon_r, ceil_r;
  dlcr_pkg::amp_t      amp_r [NL];
  dlcr_pkg::amp_t      temp_r;

  dlcr_pkg::lane_ctl_t lane_ctl [NL];
  dlcr_pkg::lane_sts_t lane_sts [NL];
  dlcr_pkg::cmd_t      cmd;
  logic                in_fire, req_ok, both_stable, any_busy, any_moved, slot_free;
  logic [2*dlcr_pkg::SUM_W:0] tprod;
  dlcr_pkg::mode_t     in_mode;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (st_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_mode   = in_tdata[3:0];
  assign slot_free = !out_valid_r || out_tready;

  // request guards: not the current mode, in range, permitted
  assign req_ok = in_tuser[0] && (in_mode != mode_r) &&
                  (in_mode < 4'(dlcr_pkg::MODE_COUNT)) &&
                  (dlcr_pkg::permit_code(in_mode) != 4'd0);

  // lanes: one per LED
  genvar g;
  generate
    for (g = 0; g < NL; g++) begin : g_lane
      assign lane_ctl[g].cmd      = cmd;
      assign lane_ctl[g].mode     = (st_r == ST_REQ_EVAL || st_r == ST_APPLY) ? want_r : mode_r;
      assign lane_ctl[g].old_mode = mode_r;
      assign lane_ctl[g].sample   = amp_r[g];
      assign lane_ctl[g].samples  = samples_r;
      assign lane_ctl[g].avg_temp = avg_r;
      assign lane_ctl[g].turn_on  = turnon_r;
      assign lane_ctl[g].ceiling  = ceil_r;
      assign lane_ctl[g].margin   = margin_r;

      dlcr_lane u_lane (
        .clk(clk), .rst_n(rst_n), .led_sel(1'(g)), .ctl(lane_ctl[g]), .sts(lane_sts[g])
      );
    end
  endgenerate

  // merge stage: lane flags combined
  always_comb begin
    both_stable = 1'b1;
    any_busy    = 1'b0;
    any_moved   = 1'b0;
    for (int i = 0; i < NL; i++) begin
      both_stable = both_stable & lane_sts[i].stable;
      any_busy    = any_busy | lane_sts[i].busy;
      any_moved   = any_moved | lane_sts[i].moved;
    end
  end

  always_comb begin
    case (st_r)
      ST_REQ_EVAL, ST_REG_EVAL: cmd = dlcr_pkg::CMD_EVAL;
      ST_APPLY:                 cmd = dlcr_pkg::CMD_APPLY;
      ST_TICK:                  cmd = dlcr_pkg::CMD_TICK;
      ST_ACC:                   cmd = both_stable ? dlcr_pkg::CMD_ACCUM : dlcr_pkg::CMD_NOP;
      ST_REGUL:                 cmd = dlcr_pkg::CMD_REGUL;
      ST_CLEAR:                 cmd = dlcr_pkg::CMD_CLEAR;
      default:                  cmd = dlcr_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    st_nxt        = st_r;
    mode_nxt      = mode_r;
    samples_nxt   = samples_r;
    tsum_nxt      = tsum_r;
    avg_nxt       = avg_r;
    wr_nxt        = wr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt1          = samples_r + 1'b1;
    // window-average temperature: sum times reciprocal of the window length
    tprod         = tsum_r * TDIV_RECIP[dlcr_pkg::SUM_W:0];
    for (int i = 0; i < NL; i++) driven_nxt[i] = driven_r[i];

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          wr_nxt = 1'b0;
          st_nxt = req_ok ? ST_REQ_EVAL : ST_TICK;
        end
      end
      ST_REQ_EVAL: st_nxt = ST_REQ_WAIT;
      ST_REQ_WAIT: begin
        if (!any_busy) st_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        mode_nxt    = want_r;
        samples_nxt = '0;
        tsum_nxt    = '0;
        st_nxt      = ST_TICK;
      end
      ST_TICK: st_nxt = ST_ACC;
      ST_ACC: begin
        st_nxt = ST_FIN;
        if (both_stable) begin
          samples_nxt = cnt1;
          tsum_nxt    = tsum_r + {8'b0, temp_r};
          if (dlcr_pkg::flash_mode(mode_r)) begin
            // flashing: blank at window start, relight at the flash-on sample
            if (cnt1 == 8'd1) begin
              for (int i = 0; i < NL; i++) driven_nxt[i] = '0;
              wr_nxt = 1'b1;
            end else if (cnt1 == 8'(FLASH_ON_SAMPLE)) begin
              for (int i = 0; i < NL; i++) driven_nxt[i] = lane_sts[i].target;
              wr_nxt = 1'b1;
            end
          end
          if (cnt1 >= 8'(WINDOW_SAMPLES)) begin
            st_nxt = dlcr_pkg::flash_mode(mode_r) ? ST_CLEAR : ST_TEMP;
          end
        end
      end
      ST_TEMP: begin
        avg_nxt = tprod[TDIV_SH +: 12];
        st_nxt  = ST_REG_EVAL;
      end
      ST_REG_EVAL: st_nxt = ST_REG_WAIT;
      ST_REG_WAIT: begin
        if (!any_busy) st_nxt = ST_REGUL;
      end
      ST_REGUL: st_nxt = ST_CLEAR;
      ST_CLEAR: begin
        samples_nxt = '0;
        tsum_nxt    = '0;
        st_nxt      = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          if (any_moved) begin
            for (int i = 0; i < NL; i++) driven_nxt[i] = lane_sts[i].target;
          end
          out_data_nxt  = {2'b00, wr_r | any_moved, both_stable, mode_r,
                           driven_nxt[1], driven_nxt[0]};
          out_valid_nxt = 1'b1;
          wr_nxt        = wr_r | any_moved;
          st_nxt        = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      mode_r      <= '0;
      samples_r   <= '0;
      tsum_r      <= '0;
      avg_r       <= '0;
      wr_r        <= 1'b0;
      out_valid_r <= 1'b0;
      margin_r    <= 4'd2;
      turnon_r    <= 8'd60;
      ceil_r      <= 8'd190;
      for (int i = 0; i < NL; i++) driven_r[i] <= '0;
    end else begin
      st_r        <= st_nxt;
      mode_r      <= mode_nxt;
      samples_r   <= samples_nxt;
      tsum_r      <= tsum_nxt;
      avg_r       <= avg_nxt;
      wr_r        <= wr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NL; i++) driven_r[i] <= driven_nxt[i];
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dlcr_pkg::CFG_MARGIN:  margin_r <= cfg_data[3:0];
          dlcr_pkg::CFG_TURN_ON: turnon_r <= cfg_data;
          dlcr_pkg::CFG_CEILING: ceil_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // item payload capture
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      want_r   <= in_mode;
      amp_r[0] <= in_tdata[15:4];
      amp_r[1] <= in_tdata[27:16];
      temp_r   <= in_tdata[39:28];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_lanes_quiet_idle, clk, rst_n, st_r == ST_IDLE, !any_busy, "lane busy in idle")
  `ASSERT_ALWAYS(a_window_bound, clk, rst_n, samples_r <= 8'(WINDOW_SAMPLES), "window count overrun")
  `ASSERT_ALWAYS(a_mode_range, clk, rst_n, mode_r < 4'(dlcr_pkg::MODE_COUNT), "lamp mode out of range")

endmodule

`default_nettype wire

// ----- sim/tb_dual_led_current_regulator.sv -----
`timescale 1ns / 1ps

module tb_dual_led_current_regulator;

  // Ramp states as seen by the tick predictor
  typedef enum logic [1:0] {RAMP_STABLE, RAMP_OFF, RAMP_UP, RAMP_DOWN} ramp_e;

  // Lamp mode table: peak current per LED, flashing flag, derating flag, permit
  localparam int PEAK_A[10] = '{0, 0, 54, 90, 54, 0, 0, 0, 0, 45};
  localparam int PEAK_B[10] = '{0, 135, 90, 0, 0, 0, 45, 135, 45, 0};
  localparam bit FLASHES[10] = '{0, 0, 0, 1, 1, 0, 1, 0, 0, 0};
  localparam bit DERATES[10] = '{0, 1, 1, 0, 0, 0, 0, 1, 0, 1};
  localparam int PERMIT[10] = '{1, 8, 1, 1, 1, 0, 9, 1, 6, 2};
  localparam int KNEE_T  = 3200;
  localparam int LIMIT_T = 3350;

  typedef struct packed {
    logic       written;
    logic       stable;
    logic [3:0] mode;
    logic [7:0] duty_b;
    logic [7:0] duty_a;
  } tick_result_t;

  // Tracks the regulator state, predicts each tick result and checks it
  class duty_scoreboard;
    logic [3:0] margin;
    logic [7:0] turn_on, ceiling;
    logic [3:0] mode;
    logic [7:0] target[2], driven[2];
    ramp_e      ramp[2];
    int         settle[2];
    int         n_samples;
    int         amp_sum[2], temp_sum;
    int         last_amp[2];
    int         avg_temp;
    int         errors, windows, mode_changes, checked;
    tick_result_t expected_q[$];

    function new();
      margin = 2; turn_on = 60; ceiling = 190; mode = 0;
      for (int i = 0; i < 2; i++) begin
        target[i] = 0; driven[i] = 0; ramp[i] = RAMP_STABLE;
        settle[i] = 0; last_amp[i] = 0; amp_sum[i] = 0;
      end
      n_samples = 0; temp_sum = 0; avg_temp = 0;
      errors = 0; windows = 0; mode_changes = 0; checked = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        dlcr_pkg::CFG_MARGIN:  margin = val[3:0];
        dlcr_pkg::CFG_TURN_ON: turn_on = val;
        dlcr_pkg::CFG_CEILING: ceiling = val;
        default: ;
      endcase
    endfunction

    function int peak(int m, int led);
      return led ? PEAK_B[m] : PEAK_A[m];
    endfunction

    // table current derated by the last window's averaged temperature
    function int goal_of(int m, int led);
      int p, a;
      p = peak(m, led);
      if (DERATES[m] && avg_temp > KNEE_T) begin
        if (avg_temp > LIMIT_T) return p >> 1;
        a = p * (LIMIT_T - avg_temp) / (LIMIT_T - KNEE_T);
        return (p >> 1) + (a >> 2) + (a >> 4);
      end
      return p;
    endfunction

    function int mean_of(int led);
      return (n_samples > 0) ? amp_sum[led] / n_samples : last_amp[led];
    endfunction

    function void clear_window();
      n_samples = 0; temp_sum = 0; amp_sum[0] = 0; amp_sum[1] = 0;
    endfunction

    function void apply_mode(int want);
      int g, mn;
      if (want == mode || want > 9 || PERMIT[want] == 0) return;
      mode_changes++;
      for (int i = 0; i < 2; i++) begin
        g = goal_of(want, i);
        mn = mean_of(i);
        if (g == 0 && target[i] > 0) ramp[i] = RAMP_OFF;
        else if (g > mn) ramp[i] = RAMP_UP;
        else if (g < mn) ramp[i] = RAMP_DOWN;
      end
      clear_window();
      settle[0] = 0; settle[1] = 0;
      if (mode != 0 && want != 0)
        for (int i = 0; i < 2; i++)
          if (peak(mode, i) == 0 && peak(want, i) > 0) target[i] = turn_on;
      mode = want[3:0];
    endfunction

    function void note_tick(logic act, logic [3:0] req, logic [11:0] amp_a,
                            logic [11:0] amp_b, logic [11:0] temp);
      bit moved, wrote, both;
      int lim, g, mn;
      tick_result_t r;
      moved = 0; wrote = 0;
      if (act) apply_mode(req);
      last_amp[0] = amp_a; last_amp[1] = amp_b;
      for (int i = 0; i < 2; i++) begin
        lim = peak(mode, i);
        case (ramp[i])
          RAMP_OFF:
            if (target[i] > 0) begin target[i]--; moved = 1; end
            else ramp[i] = RAMP_STABLE;
          RAMP_UP:
            if (last_amp[i] < lim) begin
              settle[i] = 0; moved = 1;
              if (target[i] < ceiling) target[i]++;
              else target[i] = ceiling;
            end else begin
              if (settle[i] < 15) settle[i]++;
              if (settle[i] > 10) ramp[i] = RAMP_STABLE;
            end
          RAMP_DOWN:
            if (last_amp[i] > lim) begin
              settle[i] = 0; moved = 1;
              if (target[i] > ceiling) target[i] = ceiling;
              else if (target[i] != 0) target[i]--;
            end else begin
              if (settle[i] < 15) settle[i]++;
              if (settle[i] > 2) ramp[i] = RAMP_STABLE;
            end
          default: ;
        endcase
      end
      if (ramp[0] == RAMP_STABLE && ramp[1] == RAMP_STABLE) begin
        n_samples++;
        amp_sum[0] += last_amp[0]; amp_sum[1] += last_amp[1];
        temp_sum += temp;
        if (FLASHES[mode]) begin
          if (n_samples == 1) begin
            driven[0] = 0; driven[1] = 0; wrote = 1;
          end else if (n_samples == dlcr_pkg::FLASH_ON_SAMPLE) begin
            driven[0] = target[0]; driven[1] = target[1]; wrote = 1;
          end
        end
        if (n_samples >= dlcr_pkg::WINDOW_SAMPLES) begin
          windows++;
          if (!FLASHES[mode]) begin
            // window closes: nudge each lit LED outside the dead band
            moved = 0;
            avg_temp = temp_sum / n_samples;
            for (int i = 0; i < 2; i++) begin
              g = goal_of(mode, i);
              if (g > 0) begin
                mn = mean_of(i);
                if (mn < g - int'(margin)) begin
                  if (target[i] < 255) target[i]++;
                  moved = 1;
                end else if (mn > g + int'(margin)) begin
                  if (target[i] > 0) target[i]--;
                  moved = 1;
                end
              end
            end
          end
          clear_window();
        end
      end
      if (moved) begin
        driven[0] = target[0]; driven[1] = target[1]; wrote = 1;
      end
      both = (ramp[0] == RAMP_STABLE && ramp[1] == RAMP_STABLE);
      r.duty_a = driven[0]; r.duty_b = driven[1]; r.mode = mode;
      r.stable = both; r.written = wrote;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data);
      tick_result_t got, exp;
      got = data[21:0];
      checked++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, data);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (data[23:22] !== 2'b00) begin
        $display("%0t: pad bits expected 0 actual %b", $time, data[23:22]);
        errors++;
      end
      if (got.duty_a !== exp.duty_a) begin
        $display("%0t: duty_first expected %0d actual %0d", $time, exp.duty_a, got.duty_a);
        errors++;
      end
      if (got.duty_b !== exp.duty_b) begin
        $display("%0t: duty_second expected %0d actual %0d", $time, exp.duty_b, got.duty_b);
        errors++;
      end
      if (got.mode !== exp.mode) begin
        $display("%0t: lamp_mode expected %0d actual %0d", $time, exp.mode, got.mode);
        errors++;
      end
      if (got.stable !== exp.stable) begin
        $display("%0t: all_stable expected %0b actual %0b", $time, exp.stable, got.stable);
        errors++;
      end
      if (got.written !== exp.written) begin
        $display("%0t: duty_written expected %0b actual %0b", $time, exp.written,
                 got.written);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // requested_mode, amp_first, amp_second, temp_sample
  logic [0:0]  in_tuser = '0;  // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;      // duty_first, duty_second, lamp_mode, all_stable, duty_written
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;

  duty_scoreboard sb = new();
  bit  calm = 1'b0;   // when set, neither side inserts idle cycles
  int  ticks_sent = 0;
  int  cycles = 0;

  always #4 clk = ~clk;

  dual_led_current_regulator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watchdog on total run length
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result sink: random stalls on out_tready, every transaction checked
  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata);
    end
  end

  // One tick transaction; in_tvalid stays high when the next one follows at once
  task automatic send_tick(logic act, logic [3:0] req, logic [11:0] amp_a,
                           logic [11:0] amp_b, logic [11:0] temp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {temp, amp_b, amp_a, req};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_tick(act, req, amp_a, amp_b, temp);
    ticks_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Let the block go idle before touching registers
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [11:0] near_amp(int p);
    int v;
    v = p + $urandom_range(0, 8) - 4;
    if ($urandom_range(0, 19) == 0) v = $urandom_range(0, 4095);
    return (v < 0) ? 12'd0 : 12'(v);
  endfunction

  function automatic logic [11:0] pick_temp();
    case ($urandom_range(0, 3))
      0:       return 12'($urandom_range(0, 4095));
      1:       return 12'($urandom_range(3350, 4095));
      default: return 12'($urandom_range(3150, 3400));
    endcase
  endfunction

  // Mode request followed by ticks with currents close to the table values
  task automatic mode_sequence(int len);
    int m;
    m = $urandom_range(0, 9);
    send_tick(1'b1, 4'(m), near_amp(sb.peak(sb.mode, 0)), near_amp(sb.peak(sb.mode, 1)),
              pick_temp());
    for (int k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) == 0)
        send_tick(1'b1, 4'($urandom_range(0, 15)), near_amp(sb.peak(sb.mode, 0)),
                  near_amp(sb.peak(sb.mode, 1)), pick_temp());
      else
        send_tick(1'b0, 4'($urandom_range(0, 15)), near_amp(sb.peak(sb.mode, 0)),
                  near_amp(sb.peak(sb.mode, 1)), pick_temp());
    end
  endtask

  task automatic random_phase(int n_items);
    int stop, len;
    stop = ticks_sent + n_items;
    while (ticks_sent < stop) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: send_tick(1'($urandom), 4'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom));
        1, 2: begin
          len = $urandom_range(150, 330);
          if (len > stop - ticks_sent - 1) len = stop - ticks_sent - 1;
          mode_sequence(len);
        end
        default: begin
          len = $urandom_range(5, 60);
          if (len > stop - ticks_sent - 1) len = stop - ticks_sent - 1;
          mode_sequence(len);
        end
      endcase
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, every mode incl. ignored ones, equal request
    send_tick(1'b0, 4'd0, 12'd0, 12'd0, 12'd0);
    send_tick(1'b1, 4'd0, 12'hFFF, 12'hFFF, 12'hFFF);   // same mode: ignored
    send_tick(1'b1, 4'd15, 12'd0, 12'd0, 12'd0);        // out of range
    send_tick(1'b1, 4'd10, 12'd5, 12'd5, 12'd5);
    send_tick(1'b1, 4'd5, 12'd0, 12'd0, 12'd0);         // no permit
    for (int m = 1; m <= 9; m++)
      send_tick(1'b1, 4'(m), 12'(m * 7), 12'hFFF - 12'(m), 12'($urandom));
    send_tick(1'b1, 4'd2, 12'd0, 12'd0, 12'hFFF);
    send_tick(1'b0, 4'd0, 12'd0, 12'd0, 12'd0);
    send_tick(1'b1, 4'd9, 12'hFFF, 12'hFFF, 12'd0);
    send_tick(1'b1, 4'd7, 12'd0, 12'd0, 12'hAAA);
    send_tick(1'b1, 4'd0, 12'h555, 12'hAAA, 12'h555);
    drain();

    // Register settings across phases, extremes included
    write_reg(dlcr_pkg::CFG_MARGIN, 8'd0);
    write_reg(dlcr_pkg::CFG_TURN_ON, 8'd255);
    write_reg(dlcr_pkg::CFG_CEILING, 8'd255);
    random_phase(250);
    drain();
    write_reg(dlcr_pkg::CFG_MARGIN, 8'd15);
    write_reg(dlcr_pkg::CFG_TURN_ON, 8'd0);
    write_reg(dlcr_pkg::CFG_CEILING, 8'd0);
    random_phase(150);
    drain();
    write_reg(dlcr_pkg::CFG_MARGIN, 8'($urandom_range(1, 14)));
    write_reg(dlcr_pkg::CFG_TURN_ON, 8'($urandom_range(1, 254)));
    write_reg(dlcr_pkg::CFG_CEILING, 8'($urandom_range(40, 200)));
    random_phase(350);
    drain();

    $display("%0d ticks, %0d results checked, %0d mode changes, %0d sample windows closed",
             ticks_sent, sb.checked, sb.mode_changes, sb.windows);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
